[hdl/thermistor_linearize_ema_defines.svh]
// Assertion shorthands shared by the RTL.
`ifndef THERMISTOR_LINEARIZE_EMA_DEFINES_SVH
`define THERMISTOR_LINEARIZE_EMA_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tle_pkg.sv]
package tle_pkg;

  // Field and register widths
  localparam int MV_W      = 13;
  localparam int OFFSET_W  = 18;
  localparam int ALPHA_W   = 10;
  localparam int WEIGHT_W  = 12;
  localparam int TEMP_W    = 21;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;

  // Internal widths
  localparam int OHM_W     = 18;
  localparam int DEG_W     = 8;
  localparam int RAW_W     = 19;
  localparam int DIV_NUM_W = 31;
  localparam int DIV_DEN_W = 16;

  // NTC table
  localparam int TABLE_STORED      = 34;
  localparam int TABLE_ENTRIES_DEF = 34;
  localparam int TAB_IDX_W         = $clog2(TABLE_STORED);

  // Filter state store
  localparam int STATE_DEPTH = 1;

  // Divider front end and scaling
  localparam int PULLUP_OHM = 39000;
  localparam int CLAMP_OHM  = 195652;
  localparam int SUPPLY_MV  = 1800;
  localparam int CLAMP_MV   = 1500;
  localparam int SCALE      = 1000;
  localparam int OUT_MAX    = 1048575;
  localparam int OUT_MIN    = -1048576;

  // Register reset values
  localparam int OFFSET_RST = 0;
  localparam int ALPHA_RST  = 1000;
  localparam int WEIGHT_RST = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET = 2'd0,
    REG_ALPHA  = 2'd1,
    REG_WEIGHT = 2'd2
  } cfg_reg_e;

  // Resistance of table point idx, descending with temperature
  function automatic logic [OHM_W-1:0] ntc_ohm(input logic [TAB_IDX_W-1:0] idx);
    logic [OHM_W-1:0] ohm;
    unique case (idx)
      6'd0:    ohm = 18'd188500;
      6'd1:    ohm = 18'd144300;
      6'd2:    ohm = 18'd111300;
      6'd3:    ohm = 18'd86560;
      6'd4:    ohm = 18'd67790;
      6'd5:    ohm = 18'd53460;
      6'd6:    ohm = 18'd42450;
      6'd7:    ohm = 18'd33930;
      6'd8:    ohm = 18'd27280;
      6'd9:    ohm = 18'd22070;
      6'd10:   ohm = 18'd17960;
      6'd11:   ohm = 18'd14700;
      6'd12:   ohm = 18'd12090;
      6'd13:   ohm = 18'd10000;
      6'd14:   ohm = 18'd8312;
      6'd15:   ohm = 18'd6942;
      6'd16:   ohm = 18'd5826;
      6'd17:   ohm = 18'd4911;
      6'd18:   ohm = 18'd4158;
      6'd19:   ohm = 18'd3536;
      6'd20:   ohm = 18'd3019;
      6'd21:   ohm = 18'd2588;
      6'd22:   ohm = 18'd2227;
      6'd23:   ohm = 18'd1924;
      6'd24:   ohm = 18'd1668;
      6'd25:   ohm = 18'd1451;
      6'd26:   ohm = 18'd1267;
      6'd27:   ohm = 18'd1110;
      6'd28:   ohm = 18'd975;
      6'd29:   ohm = 18'd860;
      6'd30:   ohm = 18'd760;
      6'd31:   ohm = 18'd674;
      6'd32:   ohm = 18'd599;
      default: ohm = 18'd534;
    endcase
    return ohm;
  endfunction

  // Table points sit on a 5 C grid starting at -40 C
  function automatic logic signed [DEG_W-1:0] ntc_deg(input logic [TAB_IDX_W-1:0] idx);
    int deg;
    deg = -40 + 5 * int'(idx);
    return DEG_W'(deg);
  endfunction

endpackage

[hdl/tle_ram.sv]
module tle_ram #(
  parameter int WIDTH = tle_pkg::RAW_W,
  parameter int DEPTH = tle_pkg::STATE_DEPTH,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [2**AW];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tle_div.sv]
module tle_div #(
  parameter int NUM_W = tle_pkg::DIV_NUM_W,
  parameter int DEN_W = tle_pkg::DIV_DEN_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quo_o
);

  // Restoring division, two quotient bits per cycle, truncating toward zero.
  // den_i must be nonzero.
  localparam int STEPS = (NUM_W + 1) / 2;
  localparam int PAD_W = 2 * STEPS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                    busy_q;
  logic                    done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    neg_q;
  logic [DEN_W-1:0]        den_q;
  logic [DEN_W-1:0]        rem_q;
  logic [PAD_W-1:0]        sh_q;
  logic signed [NUM_W-1:0] quo_q;

  logic [NUM_W-1:0]        mag;
  logic [DEN_W-1:0]        rem_v;
  logic [PAD_W-1:0]        sh_v;
  logic [DEN_W:0]          trial;

  assign mag = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);

  // sh holds the remaining dividend bits at the top, quotient bits enter at the bottom
  always_comb begin
    rem_v = rem_q;
    sh_v  = sh_q;
    trial = '0;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_v, sh_v[PAD_W-1]};
      sh_v  = {sh_v[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_v   = DEN_W'(trial - {1'b0, den_q});
        sh_v[0] = 1'b1;
      end else begin
        rem_v = DEN_W'(trial);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      den_q  <= '0;
      rem_q  <= '0;
      sh_q   <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS);
        neg_q  <= num_i[NUM_W-1];
        den_q  <= den_i;
        rem_q  <= '0;
        sh_q   <= PAD_W'(mag);
      end else if (busy_q) begin
        rem_q <= rem_v;
        sh_q  <= sh_v;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          quo_q  <= neg_q ? -NUM_W'(sh_v) : NUM_W'(sh_v);
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[hdl/thermistor_linearize_ema.sv]
// NTC thermistor linearizer with offset, exponential smoothing and output gain.
// Each input transfer carries one ADC reading in millivolts across the
// thermistor of a 39 kOhm pull-up divider fed from 1800 mV; each produces
// exactly one output transfer. A negative reading returns status 1 with a
// zero temperature and leaves the filter untouched. Otherwise the reading is
// turned into a resistance (above 1500 mV it clamps to 195652 Ohm),
// interpolated over the NTC table to whole degrees (-40..125 C), scaled to
// millidegrees less offset_mc, run through an EMA with weight
// smoothing_alpha/1000 (values above 1000 act as 1000), and multiplied by
// output_weight/1000 with saturation to 21 bits. All divisions truncate
// toward zero. The first sample after reset or after any register write
// loads the filter directly. One sample is processed at a time. The time
// from a reading's input transfer until its result is ready is set by
// the shared divider (per quotient: start, sixteen steps of two bits,
// handoff; up to four quotients per sample: resistance, interpolation,
// EMA and gain) and by the table walk, which tests one table segment per
// cycle. The next input transfer can be taken while the previous result
// is still waiting for its output transfer. Registers are written through
// a plain write port and should only be written while no sample is in
// flight.
`include "thermistor_linearize_ema_defines.svh"

module thermistor_linearize_ema #(
  parameter int TABLE_ENTRIES = tle_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tle_pkg::MV_W-1:0]     adc_mv_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tle_pkg::TEMP_W-1:0]   temperature_mc_o,
  output logic                                status_o,
  // register write port
  input  logic                                cfg_we_i,
  input  logic [tle_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tle_pkg::CFG_W-1:0]           cfg_wdata_i
);

  import tle_pkg::*;

  // Effective table length, clamped to between 2 and the stored points
  localparam int TAB_N = (TABLE_ENTRIES > TABLE_STORED) ? TABLE_STORED :
                         ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int IDX_W = $clog2(TAB_N);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TAB_N - 1);

  localparam int MV_U_W   = 11;                      // 0..1500 after the clamp check
  localparam int RNUM_W   = 16 + MV_U_W;             // 39000 * mv
  localparam int IP_W     = OHM_W + 1 + DEG_W;       // interpolation partial products
  localparam int RAW_X_W  = RAW_W + 1;
  localparam int EMA_P_W  = ALPHA_W + 1 + RAW_W;
  localparam int OUT_P_W  = WEIGHT_W + 1 + RAW_W;
  localparam int RAM_AW   = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

  localparam logic [15:0]               PULLUP_C   = 16'(PULLUP_OHM);
  localparam logic [MV_U_W-1:0]         SUPPLY_C   = MV_U_W'(SUPPLY_MV);
  localparam logic [MV_W-2:0]           CLAMP_MV_C = (MV_W - 1)'(CLAMP_MV);
  localparam logic [OHM_W-1:0]          CLAMP_R_C  = OHM_W'(CLAMP_OHM);
  localparam logic signed [RAW_X_W-1:0] SCALE_RAW  = RAW_X_W'(SCALE);
  localparam logic [ALPHA_W-1:0]        ALPHA_MAX  = ALPHA_W'(SCALE);
  localparam logic [DIV_DEN_W-1:0]      SCALE_DEN  = DIV_DEN_W'(SCALE);
  localparam logic signed [DIV_NUM_W-1:0] OUT_MAX_Q = DIV_NUM_W'(OUT_MAX);
  localparam logic signed [DIV_NUM_W-1:0] OUT_MIN_Q = DIV_NUM_W'(OUT_MIN);

  typedef enum logic [3:0] {
    S_IDLE,    // waiting for a reading
    S_RDIV,    // resistance division running
    S_TCHK,    // table end checks
    S_WALK,    // segment search
    S_IMUL,    // interpolation numerator ready, start division
    S_IDIV,    // interpolation division running
    S_RAW,     // millidegrees less offset
    S_EMA,     // EMA products or direct load
    S_EADD,    // start EMA division
    S_EDIV,    // EMA division running
    S_WB,      // write back filter, gain product
    S_OSTART,  // start gain division
    S_ODIV,    // gain division running
    S_OUT      // hand result to the output register
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [OFFSET_W-1:0] offset_q;
  logic [ALPHA_W-1:0]         alpha_q;
  logic [WEIGHT_W-1:0]        weight_q;
  logic                       cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_OFFSET || cfg_idx_i == REG_ALPHA ||
                                cfg_idx_i == REG_WEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_W'(OFFSET_RST);
      alpha_q  <= ALPHA_W'(ALPHA_RST);
      weight_q <= WEIGHT_W'(WEIGHT_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OFFSET: offset_q <= $signed(cfg_wdata_i[OFFSET_W-1:0]);
        REG_ALPHA:  alpha_q  <= cfg_wdata_i[ALPHA_W-1:0];
        REG_WEIGHT: weight_q <= cfg_wdata_i[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers and control
  // ---------------------------------------------------------------------------
  state_e                      state_q;
  logic [OHM_W-1:0]            r_q;
  logic [IDX_W-1:0]            idx_q;
  logic signed [DEG_W-1:0]     deg_q;
  logic signed [IP_W-1:0]      p_hi_q;
  logic signed [IP_W-1:0]      p_lo_q;
  logic signed [RAW_W-1:0]     raw_q;
  logic signed [EMA_P_W-1:0]   pa_q;
  logic signed [EMA_P_W-1:0]   pb_q;
  logic signed [RAW_W-1:0]     filt_q;
  logic signed [DIV_NUM_W-1:0] po_q;
  logic                        primed_q;
  logic signed [TEMP_W-1:0]    res_temp_q;
  logic                        res_status_q;
  logic                        out_valid_q;
  logic signed [TEMP_W-1:0]    temp_q;
  logic                        status_q;

  // divider request
  logic                        div_start_q;
  logic signed [DIV_NUM_W-1:0] div_num_q;
  logic [DIV_DEN_W-1:0]        div_den_q;
  logic                        div_done;
  logic signed [DIV_NUM_W-1:0] div_quo;

  // filter state memory
  logic                        ram_we;
  logic                        ram_re;
  logic [RAW_W-1:0]            ram_rdata;

  logic                        in_fire;
  logic                        out_free;
  logic                        mv_neg;
  logic                        mv_high;
  logic [MV_U_W-1:0]           mv_u;
  logic [RNUM_W-1:0]           r_num;
  logic [MV_U_W-1:0]           r_den;

  logic [OHM_W-1:0]            ohm_first;
  logic [OHM_W-1:0]            ohm_last;
  logic [OHM_W-1:0]            ohm_hi;
  logic [OHM_W-1:0]            ohm_lo;
  logic signed [DEG_W-1:0]     deg_first;
  logic signed [DEG_W-1:0]     deg_last;
  logic signed [DEG_W-1:0]     deg_hi;
  logic signed [DEG_W-1:0]     deg_lo;
  logic [OHM_W-1:0]            d_lo;
  logic [OHM_W-1:0]            d_hi;
  logic signed [IP_W-1:0]      prod_hi;
  logic signed [IP_W-1:0]      prod_lo;
  logic signed [RAW_X_W-1:0]   raw_full;
  logic [ALPHA_W-1:0]          alpha_eff;
  logic [ALPHA_W-1:0]          alpha_inv;
  logic signed [EMA_P_W-1:0]   prod_a;
  logic signed [EMA_P_W-1:0]   prod_b;
  logic signed [OUT_P_W-1:0]   prod_o;
  logic signed [TEMP_W-1:0]    temp_sat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // reading front end
  assign mv_neg  = adc_mv_i[MV_W-1];
  assign mv_high = adc_mv_i[MV_W-2:0] > CLAMP_MV_C;
  assign mv_u    = adc_mv_i[MV_U_W-1:0];
  assign r_num   = RNUM_W'(PULLUP_C) * RNUM_W'(mv_u);
  assign r_den   = SUPPLY_C - mv_u;

  // table lookups: ends, and the segment [idx-1, idx] under test
  assign ohm_first = ntc_ohm('0);
  assign ohm_last  = ntc_ohm(TAB_IDX_W'(IDX_LAST));
  assign deg_first = ntc_deg('0);
  assign deg_last  = ntc_deg(TAB_IDX_W'(IDX_LAST));
  assign ohm_hi    = ntc_ohm(TAB_IDX_W'(idx_q - 1'b1));
  assign ohm_lo    = ntc_ohm(TAB_IDX_W'(idx_q));
  assign deg_hi    = ntc_deg(TAB_IDX_W'(idx_q - 1'b1));
  assign deg_lo    = ntc_deg(TAB_IDX_W'(idx_q));

  // inside a segment rl <= r < rh, so both differences are nonnegative
  assign d_lo    = r_q - ohm_lo;
  assign d_hi    = ohm_hi - r_q;
  assign prod_hi = IP_W'($signed({1'b0, d_lo})) * IP_W'(deg_hi);
  assign prod_lo = IP_W'($signed({1'b0, d_hi})) * IP_W'(deg_lo);

  // raw fits 19 bits for any offset in the 18-bit range
  assign raw_full = RAW_X_W'(deg_q) * SCALE_RAW - RAW_X_W'(offset_q);

  assign alpha_eff = (alpha_q > ALPHA_MAX) ? ALPHA_MAX : alpha_q;
  assign alpha_inv = ALPHA_MAX - alpha_eff;
  assign prod_a    = EMA_P_W'($signed({1'b0, alpha_eff})) * EMA_P_W'(raw_q);
  assign prod_b    = EMA_P_W'($signed({1'b0, alpha_inv})) * EMA_P_W'($signed(ram_rdata));
  assign prod_o    = OUT_P_W'($signed({1'b0, weight_q})) * OUT_P_W'(filt_q);

  always_comb begin
    if (div_quo > OUT_MAX_Q) begin
      temp_sat = TEMP_W'(OUT_MAX);
    end else if (div_quo < OUT_MIN_Q) begin
      temp_sat = TEMP_W'(OUT_MIN);
    end else begin
      temp_sat = TEMP_W'(div_quo);
    end
  end

  // Filter value is read at the input transfer and written back before the
  // next one can be taken, so read and write never overlap.
  assign ram_re = in_fire;
  assign ram_we = (state_q == S_WB);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      r_q          <= '0;
      idx_q        <= IDX_FIRST;
      deg_q        <= '0;
      p_hi_q       <= '0;
      p_lo_q       <= '0;
      raw_q        <= '0;
      pa_q         <= '0;
      pb_q         <= '0;
      filt_q       <= '0;
      po_q         <= '0;
      primed_q     <= 1'b0;
      res_temp_q   <= '0;
      res_status_q <= 1'b0;
      out_valid_q  <= 1'b0;
      temp_q       <= '0;
      status_q     <= 1'b0;
      div_start_q  <= 1'b0;
      div_num_q    <= '0;
      div_den_q    <= '0;
    end else begin
      div_start_q <= 1'b0;

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // any register write restarts the filter
      if (cfg_hit) begin
        primed_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (mv_neg) begin
              res_temp_q   <= '0;
              res_status_q <= 1'b1;
              state_q      <= S_OUT;
            end else if (mv_high) begin
              r_q     <= CLAMP_R_C;
              state_q <= S_TCHK;
            end else begin
              div_start_q <= 1'b1;
              div_num_q   <= DIV_NUM_W'(r_num);
              div_den_q   <= DIV_DEN_W'(r_den);
              state_q     <= S_RDIV;
            end
          end
        end
        S_RDIV: begin
          if (div_done) begin
            r_q     <= OHM_W'(div_quo);
            state_q <= S_TCHK;
          end
        end
        S_TCHK: begin
          idx_q <= IDX_FIRST;
          if (r_q >= ohm_first) begin
            deg_q   <= deg_first;
            state_q <= S_RAW;
          end else if (r_q <= ohm_last) begin
            deg_q   <= deg_last;
            state_q <= S_RAW;
          end else begin
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          // always terminates: r is above the last table point
          if (r_q >= ohm_lo) begin
            p_hi_q    <= prod_hi;
            p_lo_q    <= prod_lo;
            div_den_q <= DIV_DEN_W'(ohm_hi - ohm_lo);
            state_q   <= S_IMUL;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IMUL: begin
          div_start_q <= 1'b1;
          div_num_q   <= DIV_NUM_W'(p_hi_q) + DIV_NUM_W'(p_lo_q);
          state_q     <= S_IDIV;
        end
        S_IDIV: begin
          if (div_done) begin
            deg_q   <= DEG_W'(div_quo);
            state_q <= S_RAW;
          end
        end
        S_RAW: begin
          raw_q   <= RAW_W'(raw_full);
          state_q <= S_EMA;
        end
        S_EMA: begin
          if (!primed_q) begin
            filt_q  <= raw_q;
            state_q <= S_WB;
          end else begin
            pa_q    <= prod_a;
            pb_q    <= prod_b;
            state_q <= S_EADD;
          end
        end
        S_EADD: begin
          div_start_q <= 1'b1;
          div_num_q   <= DIV_NUM_W'(pa_q) + DIV_NUM_W'(pb_q);
          div_den_q   <= SCALE_DEN;
          state_q     <= S_EDIV;
        end
        S_EDIV: begin
          if (div_done) begin
            filt_q  <= RAW_W'(div_quo);
            state_q <= S_WB;
          end
        end
        S_WB: begin
          primed_q <= 1'b1;
          po_q     <= DIV_NUM_W'(prod_o);
          state_q  <= S_OSTART;
        end
        S_OSTART: begin
          div_start_q <= 1'b1;
          div_num_q   <= po_q;
          div_den_q   <= SCALE_DEN;
          state_q     <= S_ODIV;
        end
        S_ODIV: begin
          if (div_done) begin
            res_temp_q   <= temp_sat;
            res_status_q <= 1'b0;
            state_q      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            temp_q      <= res_temp_q;
            status_q    <= res_status_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign temperature_mc_o = temp_q;
  assign status_o         = status_q;

  // ---------------------------------------------------------------------------
  // Shared divider and filter state memory
  // ---------------------------------------------------------------------------
  tle_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  tle_ram #(
    .WIDTH (RAW_W),
    .DEPTH (STATE_DEPTH)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (RAM_AW'(0)),
    .wdata_i (filt_q),
    .re_i    (ram_re),
    .raddr_i (RAM_AW'(0)),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic div_wait;
  logic walk_idx_ok;

  assign div_wait    = (state_q == S_RDIV) || (state_q == S_IDIV) ||
                       (state_q == S_EDIV) || (state_q == S_ODIV);
  assign walk_idx_ok = (idx_q != '0) && (idx_q <= IDX_LAST);

  `TLE_ASSERT_NEXT(a_one_sample, clk_i, rst_ni, in_fire, in_stall_o, "sample taken while busy")
  `TLE_ASSERT_NOW(a_div_owner, clk_i, rst_ni, div_done, div_wait, "divider done while idle")
  `TLE_ASSERT_NOW(a_walk_range, clk_i, rst_ni, state_q == S_WALK, walk_idx_ok, "walk index bad")
  `TLE_ASSERT_NEXT(a_wb_primes, clk_i, rst_ni, ram_we, primed_q, "filter written but unprimed")

endmodule
